// ===== hdl/bfd_pkg.sv =====
// ---------------------------------------------------------------------------
// bfd_pkg
// Shared widths, defaults and register codes of the direction-to-basis core.
// ---------------------------------------------------------------------------
package bfd_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int DIR_WIDTH_DEF = 16;
   localparam int ROW_W         = 16;
   localparam int POS_W         = 32;
   localparam int CSR_IDX_W     = 2;

   // reference-axis switch: |g.z| * THR_DEN > THR_NUM * 2^F
   localparam int THR_NUM = 999;
   localparam int THR_DEN = 1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIRROR_X = 2'd0,
      CSR_MIRROR_Y = 2'd1,
      CSR_MIRROR_Z = 2'd2
   } csr_index_type;

endpackage

// ===== hdl/bfd_norm.sv =====
// ---------------------------------------------------------------------------
// bfd_norm
// Pipelined 3-vector normaliser: one result bit per search stage, nearest rounding.
// ---------------------------------------------------------------------------
module bfd_norm
   import bfd_pkg::*;
#(
   parameter int VW = 16,
   parameter int F  = 14
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [VW-1:0] vec_in  [0:2],
   output logic signed [F+1:0]  unit_out [0:2]
);

   localparam int SW = 2*VW + 2;
   localparam int CW = 2*VW + 2*F + 5;
   localparam int QW = F + 1;
   localparam int NL = F + 2;

   logic [2*VW-1:0]       sq_ff  [0:2];
   logic                  neg0_ff [0:2];
   logic [VW-1:0]         mag_w  [0:2];

   logic [SW-1:0]         s_ff    [0:NL-1];
   logic                  zero_ff [0:NL-1];
   logic                  neg_ff  [0:NL-1][0:2];
   logic signed [CW-1:0]  x_ff    [0:NL-1][0:2];
   logic signed [CW-1:0]  y_ff    [0:NL-1][0:2];
   logic signed [CW-1:0]  r_ff    [0:NL-1][0:2];
   logic [QW-1:0]         q_ff    [0:NL-1][0:2];
   logic [SW-1:0]         s_in;

   // squares of the magnitudes
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_w[i] = vec_in[i][VW-1] ? VW'(-vec_in[i]) : VW'(vec_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i]   <= (2*VW)'(mag_w[i]) * (2*VW)'(mag_w[i]);
            neg0_ff[i] <= vec_in[i][VW-1];
         end
      end
   end

   // sum of squares; seed the search with (2q-1)^2*s = s, (2q-1)*s = -s
   assign s_in = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff[0]    <= s_in;
         zero_ff[0] <= (s_in == '0);
         for (int i = 0; i < 3; i++) begin
            neg_ff[0][i] <= neg0_ff[i];
            x_ff[0][i]   <= CW'(s_in);
            y_ff[0][i]   <= -CW'(s_in);
            r_ff[0][i]   <= CW'(sq_ff[i]) << (2*F + 2);
            q_ff[0][i]   <= '0;
         end
      end
   end

   // one quotient bit per stage, MSB first; only adds, shifts and a compare
   for (genvar k = 0; k < QW; k++) begin : g_bit
      localparam int B = F - k;
      logic signed [CW-1:0] cand [0:2];
      logic                 acc  [0:2];
      logic signed [CW-1:0] s_ext;

      assign s_ext = CW'(s_ff[k]);

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            cand[i] = x_ff[k][i] + (y_ff[k][i] <<< (B + 2)) + (s_ext <<< (2*B + 2));
            acc[i]  = !q_ff[k][i][F] && (cand[i] <= r_ff[k][i]);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[k+1]    <= s_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            for (int i = 0; i < 3; i++) begin
               neg_ff[k+1][i] <= neg_ff[k][i];
               r_ff[k+1][i]   <= r_ff[k][i];
               if (acc[i]) begin
                  x_ff[k+1][i] <= cand[i];
                  y_ff[k+1][i] <= y_ff[k][i] + (s_ext <<< (B + 1));
                  q_ff[k+1][i] <= q_ff[k][i] | QW'(1 << B);
               end else begin
                  x_ff[k+1][i] <= x_ff[k][i];
                  y_ff[k+1][i] <= y_ff[k][i];
                  q_ff[k+1][i] <= q_ff[k][i];
               end
            end
         end
      end
   end

   // reapply sign; a zero vector gives zeros
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (zero_ff[NL-1]) begin
               unit_out[i] <= '0;
            end else if (neg_ff[NL-1][i]) begin
               unit_out[i] <= -$signed({1'b0, q_ff[NL-1][i]});
            end else begin
               unit_out[i] <= $signed({1'b0, q_ff[NL-1][i]});
            end
         end
      end
   end

endmodule

// ===== hdl/basis_from_direction_core.sv =====
// ---------------------------------------------------------------------------
// basis_from_direction_core
// Orthonormal frame (right, up, back rows) from a forward vector.
// ---------------------------------------------------------------------------
// The core takes one transfer per cycle while the pipeline advances and
// returns one result transfer per input, in order. Its path is three
// normaliser pipelines of FRAC_BITS + 4 stages each (one result bit per
// search stage), one mirror/axis stage, two cross product stages and the
// output register. The whole pipeline advances while the output register is
// empty or being taken, and req_tready is high exactly while it advances;
// a stall then freezes every pipeline stage and nothing is lost or repeated.
// The forward vector is normalised to g in Q1.FRAC_BITS (nearest, ties away
// from zero), each component optionally negated by its mirror bit, then
// right = normalise(g x ref) with ref = +Z, or +Y when |g.z| > 0.999,
// up = normalise(round(right x g)) and back = -g. A zero vector gives zero
// rows. The position is passed through untouched. Mirror bits are written
// over the csr channel, which is always ready; write them only while idle.
// ---------------------------------------------------------------------------
module basis_from_direction_core
   import bfd_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int DIR_WIDTH = DIR_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // fwd_x, fwd_y, fwd_z (DIR_WIDTH each), pos_x, pos_y, pos_z (32 each), zero pad
   input  logic [((3*DIR_WIDTH+3*POS_W+7)/8)*8-1:0] req_tdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // right_x/y/z, up_x/y/z, back_x/y/z (16 each), origin_x/y/z (32 each)
   output logic [9*ROW_W+3*POS_W-1:0] rsp_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_data
);

   localparam int F  = FRAC_BITS;
   localparam int DW = DIR_WIDTH;
   localparam int GW = F + 2;         // unit components, +-2^F
   localparam int PW = 2*F + 4;       // products of two unit components
   localparam int UW = F + 4;         // rounded cross product
   localparam int L  = F + 4;         // normaliser latency
   localparam int T  = 3*L + 4;       // total latency
   localparam int GD = 2*L + 2;       // g delay line length
   localparam int MW = F + 12;        // threshold compare width
   localparam logic signed [GW-1:0] ONE_G = GW'(1 << F);

   logic adv;
   logic mir_ff [0:2];

   logic signed [DW-1:0] fwd_w   [0:2];
   logic signed [GW-1:0] g_w     [0:2];
   logic signed [GW-1:0] gm_ff   [0:2];
   logic signed [GW-1:0] r_ff    [0:2];
   logic signed [GW-1:0] rn_w    [0:2];
   logic signed [GW-1:0] gd_ff   [0:GD-1][0:2];
   logic signed [PW-1:0] p_ff    [0:5];
   logic signed [UW-1:0] u_ff    [0:2];
   logic signed [GW-1:0] un_w    [0:2];
   logic [POS_W-1:0]     pos_ff  [0:T-1][0:2];
   logic                 vld_ff  [0:T-1];

   logic signed [GW-1:0] gmir_w  [0:2];
   logic [GW-1:0]        gz_mag;
   logic                 use_y;

   logic signed [GW-1:0] right_ff [0:2];
   logic signed [GW-1:0] up_ff    [0:2];
   logic signed [GW-1:0] back_ff  [0:2];

   // ---- handshakes --------------------------------------------------------
   // advance the whole pipe while the output register can take a new item
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[T-1];
   assign csr_ready  = 1'b1;

   // ---- mirror registers --------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) mir_ff[i] <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIRROR_X: mir_ff[0] <= csr_data;
            CSR_MIRROR_Y: mir_ff[1] <= csr_data;
            CSR_MIRROR_Z: mir_ff[2] <= csr_data;
            default:      ;  // drop writes beyond the register list
         endcase
      end
   end

   // ---- valid and position tracks ----------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < T; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < T; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[0][i] <= req_tdata[3*DW + i*POS_W +: POS_W];
         end
         for (int k = 1; k < T; k++) pos_ff[k] <= pos_ff[k-1];
      end
   end

   // ---- normalise the forward vector --------------------------------------
   always_comb begin
      for (int i = 0; i < 3; i++) fwd_w[i] = req_tdata[i*DW +: DW];
   end

   bfd_norm #(.VW(DW), .F(F)) u_norm_fwd (
      .clock    (clock),
      .en       (adv),
      .vec_in   (fwd_w),
      .unit_out (g_w)
   );

   // ---- mirror, pick the reference axis, form g x ref ---------------------
   always_comb begin
      for (int i = 0; i < 3; i++) gmir_w[i] = mir_ff[i] ? -g_w[i] : g_w[i];
      gz_mag = gmir_w[2][GW-1] ? GW'(-gmir_w[2]) : GW'(gmir_w[2]);
      use_y  = (MW'(gz_mag) * MW'(THR_DEN)) > (MW'(THR_NUM) << F);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gm_ff <= gmir_w;
         if (use_y) begin
            r_ff[0] <= -gmir_w[2];
            r_ff[1] <= '0;
            r_ff[2] <= gmir_w[0];
         end else begin
            r_ff[0] <= gmir_w[1];
            r_ff[1] <= -gmir_w[0];
            r_ff[2] <= '0;
         end
      end
   end

   // hold g until the cross product and the back row need it
   always_ff @(posedge clock) begin
      if (adv) begin
         gd_ff[0] <= gm_ff;
         for (int k = 1; k < GD; k++) gd_ff[k] <= gd_ff[k-1];
      end
   end

   bfd_norm #(.VW(GW), .F(F)) u_norm_right (
      .clock    (clock),
      .en       (adv),
      .vec_in   (r_ff),
      .unit_out (rn_w)
   );

   // ---- up = round(right x g) at Q2.2F, back to Q.F -----------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff[0] <= PW'(rn_w[1]) * PW'(gd_ff[L-1][2]);
         p_ff[1] <= PW'(rn_w[2]) * PW'(gd_ff[L-1][1]);
         p_ff[2] <= PW'(rn_w[2]) * PW'(gd_ff[L-1][0]);
         p_ff[3] <= PW'(rn_w[0]) * PW'(gd_ff[L-1][2]);
         p_ff[4] <= PW'(rn_w[0]) * PW'(gd_ff[L-1][1]);
         p_ff[5] <= PW'(rn_w[1]) * PW'(gd_ff[L-1][0]);
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_round
      logic signed [PW:0] diff;
      logic [PW:0]        dmag;
      logic [PW:0]        rnd;
      assign diff = (PW+1)'(p_ff[2*i]) - (PW+1)'(p_ff[2*i+1]);
      assign dmag = diff[PW] ? (PW+1)'(-diff) : (PW+1)'(diff);
      assign rnd  = (dmag + (PW+1)'(1 << (F-1))) >> F;
      always_ff @(posedge clock) begin
         if (adv) begin
            // halves round away from zero
            u_ff[i] <= diff[PW] ? -$signed(UW'(rnd)) : $signed(UW'(rnd));
         end
      end
   end

   bfd_norm #(.VW(UW), .F(F)) u_norm_up (
      .clock    (clock),
      .en       (adv),
      .vec_in   (u_ff),
      .unit_out (un_w)
   );

   // ---- output register ---------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            up_ff[i]   <= un_w[i];
            back_ff[i] <= -gd_ff[GD-1][i];
         end
      end
   end

   // right row travels alongside the up normaliser
   logic signed [GW-1:0] rd_ff [0:L+2][0:2];
   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff[0] <= rn_w;
         for (int k = 1; k < L + 3; k++) rd_ff[k] <= rd_ff[k-1];
      end
   end
   assign right_ff = rd_ff[L+2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rsp_tdata[i*ROW_W +: ROW_W]     = ROW_W'(right_ff[i]);
         rsp_tdata[(3+i)*ROW_W +: ROW_W] = ROW_W'(up_ff[i]);
         rsp_tdata[(6+i)*ROW_W +: ROW_W] = ROW_W'(back_ff[i]);
         rsp_tdata[9*ROW_W + i*POS_W +: POS_W] = pos_ff[T-1][i];
      end
   end

   // ---- checks ------------------------------------------------------------
   a_back_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (back_ff[0] <= ONE_G && back_ff[0] >= -ONE_G &&
                      back_ff[1] <= ONE_G && back_ff[1] >= -ONE_G &&
                      back_ff[2] <= ONE_G && back_ff[2] >= -ONE_G))
      else $error("back row outside unit range");

   a_up_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (up_ff[0] <= ONE_G && up_ff[0] >= -ONE_G &&
                      up_ff[1] <= ONE_G && up_ff[1] >= -ONE_G &&
                      up_ff[2] <= ONE_G && up_ff[2] >= -ONE_G))
      else $error("up row outside unit range");

   a_right_z: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && right_ff[2] != '0) |->
         ((MW'(back_ff[2][GW-1] ? -back_ff[2] : back_ff[2]) * MW'(THR_DEN)) >
          (MW'(THR_NUM) << F)))
      else $error("right row has z without the +Y reference");

endmodule
